// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, quiet while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check that an implication holds into the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: hw/rtl/cll_pkg.sv
package cll_pkg;

  localparam int unsigned NODES  = 16;
  localparam int unsigned IDX_W  = $clog2(NODES);
  localparam int unsigned LINK_W = IDX_W + 1;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [1:0] {
    OP_INS_HEAD = 2'd0,
    OP_INS_TAIL = 2'd1,
    OP_SEARCH   = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    EMIT_NONE  = 3'd0,
    EMIT_FULL  = 3'd1,
    EMIT_ALLOC = 3'd2,
    EMIT_TAIL  = 3'd3,
    EMIT_HIT   = 3'd4,
    EMIT_MISS  = 3'd5,
    EMIT_READ  = 3'd6,
    EMIT_EMPTY = 3'd7
  } emit_e;

  typedef struct packed {
    logic  accept;     // latch op, value and start cursor
    logic  alloc;      // pop free node, write its value and link
    logic  link_tail;  // hook held node after the cursor
    logic  advance;    // cursor follows its link
    emit_e emit;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic head_ok;
    logic free_ok;
    logic cur_ok;
    logic next_ok;
    logic match;
  } stat_t;

  function automatic logic link_ok(link_t l);
    return l < NIL;
  endfunction

endpackage

// File: hw/rtl/cursor_linked_list_engine_unit.sv
// Channel   Handshake               Fields
// command   start_i / busy_o        op_i, value_in_i
// result    result_valid_o strobe   status_o, found_o, node_index_o, value_out_o, last_o
//
// A command is taken when start_i is high and busy_o is low; the next one can follow
// as soon as busy_o falls. Head insert does not walk the list; tail insert, search and
// read out walk one link per cycle, the longest walk being a search that misses a full list.
// Read out gives one result beat per node on consecutive cycles.
// Reset is asynchronous, active low; the free chain is restored at once.
// Results cannot be stalled: each beat is shown for exactly one cycle.
module cursor_linked_list_engine_unit
  import cll_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       op_i,
  input  logic [7:0]       value_in_i,
  output logic             result_valid_o,
  output logic [1:0]       status_o,
  output logic             found_o,
  output logic [IDX_W-1:0] node_index_o,
  output logic [7:0]       value_out_o,
  output logic             last_o
);

  cmd_t  cmd;
  stat_t stat;
  op_e   op;

  assign op = op_e'(op_i);

  cll_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  cll_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .value_in_i     (value_in_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_o        (found_o),
    .node_index_o   (node_index_o),
    .value_out_o    (value_out_o),
    .last_o         (last_o)
  );

endmodule

// File: hw/rtl/cll_ctrl.sv
module cll_ctrl
  import cll_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  op_e   op_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ALLOC  = 5'b00010,
    ST_TAIL   = 5'b00100,
    ST_SEARCH = 5'b01000,
    ST_READ   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d           = state_q;
    cmd_o.accept      = 1'b0;
    cmd_o.alloc       = 1'b0;
    cmd_o.link_tail   = 1'b0;
    cmd_o.advance     = 1'b0;
    cmd_o.emit        = EMIT_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          unique case (op_i)
            OP_INS_HEAD, OP_INS_TAIL: state_d = ST_ALLOC;
            OP_SEARCH:                state_d = ST_SEARCH;
            OP_READ:                  state_d = ST_READ;
            default:                  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ALLOC: begin
        if (!stat_i.free_ok) begin
          cmd_o.emit = EMIT_FULL;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.alloc = 1'b1;
          if (stat_i.op == OP_INS_HEAD || !stat_i.head_ok) begin
            cmd_o.emit = EMIT_ALLOC;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (stat_i.next_ok) begin
          cmd_o.advance = 1'b1;
        end else begin
          cmd_o.link_tail = 1'b1;
          cmd_o.emit      = EMIT_TAIL;
          state_d         = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (!stat_i.cur_ok) begin
          cmd_o.emit = EMIT_MISS;
          state_d    = ST_IDLE;
        end else if (stat_i.match) begin
          cmd_o.emit = EMIT_HIT;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_READ: begin
        if (!stat_i.cur_ok) begin
          cmd_o.emit = EMIT_EMPTY;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.emit    = EMIT_READ;
          cmd_o.advance = 1'b1;
          if (!stat_i.next_ok) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted beat did not start work")
  `ASSERT_CLK(a_idle_quiet, !busy_o |-> cmd_o.emit == EMIT_NONE, "result emitted while idle")
  `ASSERT_CLK(a_tail_has_head, state_q == ST_TAIL |-> stat_i.head_ok, "tail walk on empty list")

endmodule

// File: hw/rtl/cll_dpath.sv
module cll_dpath
  import cll_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  op_e                    op_i,
  input  logic [7:0]             value_in_i,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  output logic                   result_valid_o,
  output logic [1:0]             status_o,
  output logic                   found_o,
  output logic [IDX_W-1:0]       node_index_o,
  output logic [7:0]             value_out_o,
  output logic                   last_o
);

  logic [7:0] value_mem_q [NODES];
  link_t      next_mem_q  [NODES];

  link_t      list_head_q, list_head_d;
  link_t      free_head_q, free_head_d;
  link_t      cur_q, cur_d;
  idx_t       node_q;
  op_e        op_q;
  logic [7:0] key_q;

  idx_t       cur_idx, free_idx;
  link_t      cur_next, free_next;
  logic       next_we;
  idx_t       next_waddr;
  link_t      next_wdata;

  logic          strobe_q;
  status_e       status_q;
  logic          found_q;
  idx_t          index_q;
  logic [7:0]    vout_q;
  logic          last_q;

  assign cur_idx   = cur_q[IDX_W-1:0];
  assign free_idx  = free_head_q[IDX_W-1:0];
  assign cur_next  = next_mem_q[cur_idx];
  assign free_next = next_mem_q[free_idx];

  assign stat_o.op      = op_q;
  assign stat_o.head_ok = link_ok(list_head_q);
  assign stat_o.free_ok = link_ok(free_head_q);
  assign stat_o.cur_ok  = link_ok(cur_q);
  assign stat_o.next_ok = link_ok(cur_next);
  assign stat_o.match   = (value_mem_q[cur_idx] == key_q);

  always_comb begin
    list_head_d = list_head_q;
    free_head_d = free_head_q;
    cur_d       = cur_q;
    next_we     = 1'b0;
    next_waddr  = free_idx;
    next_wdata  = NIL;
    if (cmd_i.accept) begin
      cur_d = list_head_q;
    end
    if (cmd_i.alloc) begin
      free_head_d = free_next;
      next_we     = 1'b1;
      if (op_q == OP_INS_HEAD) begin
        next_wdata  = list_head_q;
        list_head_d = free_head_q;
      end else if (!link_ok(list_head_q)) begin
        list_head_d = free_head_q;
      end
    end
    if (cmd_i.link_tail) begin
      next_we    = 1'b1;
      next_waddr = cur_idx;
      next_wdata = {1'b0, node_q};
    end
    if (cmd_i.advance) begin
      cur_d = cur_next;
    end
  end

  // Link store resets to a free chain: each node points one index lower, node 0 to NIL.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        next_mem_q[i] <= (i == 0) ? NIL : LINK_W'(i - 1);
      end
    end else if (next_we) begin
      next_mem_q[next_waddr] <= next_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      value_mem_q[free_idx] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_head_q <= NIL;
      free_head_q <= LINK_W'(NODES - 1);
    end else begin
      list_head_q <= list_head_d;
      free_head_q <= free_head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.accept) begin
      op_q  <= op_i;
      key_q <= value_in_i;
    end
    if (cmd_i.alloc) begin
      node_q <= free_idx;
    end
  end

  // Result register: one beat per emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (cmd_i.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= STATUS_OK;
    found_q  <= 1'b0;
    index_q  <= '0;
    vout_q   <= '0;
    last_q   <= 1'b1;
    case (cmd_i.emit)
      EMIT_FULL:  status_q <= STATUS_FULL;
      EMIT_ALLOC: index_q  <= free_idx;
      EMIT_TAIL:  index_q  <= node_q;
      EMIT_HIT: begin
        found_q <= 1'b1;
        index_q <= cur_idx;
      end
      EMIT_READ: begin
        index_q <= cur_idx;
        vout_q  <= value_mem_q[cur_idx];
        last_q  <= !link_ok(cur_next);
      end
      EMIT_EMPTY: status_q <= STATUS_EMPTY;
      default: ;
    endcase
  end

  assign result_valid_o = strobe_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign node_index_o   = index_q;
  assign value_out_o    = vout_q;
  assign last_o         = last_q;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_head_sticky, link_ok(list_head_q), link_ok(list_head_q), "list head lost")
  `ASSERT_NEXT(a_read_burst, strobe_q && !last_q, strobe_q, "read out beat gap")
  `ASSERT_CLK(a_full_real, strobe_q && status_q == STATUS_FULL |-> !link_ok(free_head_q),
              "full reported with free nodes")

endmodule
